>>> rtl/nbc_pkg.sv
// Shared types, constants and arithmetic helpers for the binary naive Bayes
// classifier: Mitchell log2, saturating score add, stream and result layouts.
// No dependencies.
`default_nettype none

package nbc_pkg;

	// Fixed data widths
	localparam int COUNT_BITS         = 16;
	localparam int FRACTION_BITS      = 16;
	localparam int SCORE_BITS         = 32;
	localparam int NUM_ATTR_BITS      = 9;
	localparam int IDX_BITS           = 8;
	localparam int MAX_ATTRIBUTES_DEF = 256;

	// Log operand holds 2*N+2 for the largest count
	localparam int LOG_IN_BITS  = COUNT_BITS + 2;
	localparam int LOG_INT_BITS = $clog2(LOG_IN_BITS);
	localparam int LOG_BITS     = LOG_INT_BITS + FRACTION_BITS;
	localparam int TERM_BITS    = LOG_BITS + 1;

	// Result queue, a power of two
	localparam int OUT_DEPTH = 8;

	// Stream and register port widths
	localparam int S_TDATA_BITS  = 32;
	localparam int M_TDATA_BITS  = 72;
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	// Item kinds carried in tuser
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_ATTR = 1'b1;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_NUM_ATTR  = 2'd0;
	localparam logic [1:0] REG_NEG_COUNT = 2'd1;
	localparam logic [1:0] REG_POS_COUNT = 2'd2;

	localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
	localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};

	typedef logic [COUNT_BITS-1:0]           count_t;
	typedef logic [LOG_BITS-1:0]             log_t;
	typedef logic signed [TERM_BITS-1:0]     term_t;
	typedef logic signed [SCORE_BITS-1:0]    score_t;
	typedef logic [NUM_ATTR_BITS-1:0]        num_attr_t;

	typedef enum logic [1:0] {
		SIGN_NEG = 2'd0,
		SIGN_TIE = 2'd1,
		SIGN_POS = 2'd2
	} sign_t;

	// Per-attribute control handed to the score pipeline
	typedef struct packed {
		logic attr_bit;
		logic attr_last;
		logic in_range;
		logic length_error;
	} attr_ctl_t;

	// Result item, class_sign in the lowest bits
	typedef struct packed {
		score_t pos_score;
		score_t neg_score;
		logic   length_error;
		sign_t  class_sign;
	} result_t;

	// Mitchell log2: exponent plus the bits below the leading one as fraction,
	// fraction floored; zero maps to zero
	function automatic log_t mitchell_log2(input logic [LOG_IN_BITS-1:0] x);
		logic [LOG_INT_BITS-1:0]              e;
		logic [LOG_IN_BITS-1:0]               m;
		logic [LOG_IN_BITS+FRACTION_BITS-1:0] w;
		e = '0;
		for (int i = 1; i < LOG_IN_BITS; i++) begin
			if (x[i]) begin
				e = LOG_INT_BITS'(i);
			end
		end
		m = x & ~(LOG_IN_BITS'(1) << e);
		w = {m, {FRACTION_BITS{1'b0}}} >> e;
		return {e, w[FRACTION_BITS-1:0]};
	endfunction

	// Add a term to a score, clamp to the signed score range
	function automatic score_t sat_add(input score_t acc, input term_t t);
		logic signed [SCORE_BITS:0] s;
		s = (SCORE_BITS+1)'(acc) + (SCORE_BITS+1)'(t);
		if (s[SCORE_BITS] != s[SCORE_BITS-1]) begin
			return s[SCORE_BITS] ? SCORE_MIN : SCORE_MAX;
		end
		return s[SCORE_BITS-1:0];
	endfunction

	// Matching-instance count: stored count when set, else the rest of the class
	function automatic count_t pick_count(input logic b, input count_t c, input count_t total);
		if (b) begin
			return c;
		end
		return (total > c) ? count_t'(total - c) : '0;
	endfunction

endpackage

`default_nettype wire

>>> rtl/binary_naive_bayes_classifier_unit.sv
// Top level of the binary naive Bayes classifier: register port, attribute
// position tracking, result credit. Depends on nbc_pkg, nbc_count_mem,
// nbc_score and nbc_out_fifo.
//
// Usage:
//   Input stream (s_axis): tuser selects the item kind. A load transfer
//   (tuser 0) writes one count table entry; loads with an index at or above
//   MAX_ATTRIBUTES are dropped. An attribute transfer (tuser 1) carries one bit
//   of the instance, tlast marks its final bit.
//   Output stream (m_axis): one result per instance, sent after the tlast
//   attribute: class sign, length error flag and both Q15.16 scores.
//   Throughput: one input transfer per cycle while s_axis_tready is high,
//   loads and attributes alike; the per-class accumulate takes back-to-back attributes.
//   Path: a result passes the table read, the score stages and the result queue.
//   Back-pressure: an 8-entry result queue absorbs output stalls. s_axis_tready
//   drops while 8 instances are accepted and not yet sent.
//   Reset: position and scores clear, num_attributes is 1, class totals 0;
//   the count table holds nothing until loaded. No clearing pass is run.
//   Registers (APB; the user writes them while the block is idle, unenforced):
//   0x0 num_attributes, 0x4 class_neg_count, 0x8 class_pos_count.
`default_nettype none

module binary_naive_bayes_classifier_unit import nbc_pkg::*; #(
	parameter int MAX_ATTRIBUTES = MAX_ATTRIBUTES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// Register port
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0]      prdata,
	output logic                          pready,
	// Input stream
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	// [7:0] load_attr_index, [8] load_class, [24:9] load_count, [25] attr_bit
	input  wire logic [S_TDATA_BITS-1:0]  s_axis_tdata,
	// [0] func
	input  wire logic                     s_axis_tuser,
	input  wire logic                     s_axis_tlast,
	// Output stream
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	// [1:0] class_sign, [2] length_error, [34:3] neg_score, [66:35] pos_score
	output logic [M_TDATA_BITS-1:0]       m_axis_tdata
);

	localparam int AW       = (MAX_ATTRIBUTES > 1) ? $clog2(MAX_ATTRIBUTES) : 1;
	localparam int PW       = $clog2(MAX_ATTRIBUTES + 2);
	localparam int CRED_BITS = $clog2(OUT_DEPTH + 1);

	num_attr_t             num_attr_q;
	count_t                neg_count_q, pos_count_q;
	logic [PW-1:0]         pos_q;
	logic [CRED_BITS-1:0]  cred_q;

	logic            cfg_wr, in_fire, attr_fire, load_fire, load_ok, res_start, out_fire;
	logic [IDX_BITS-1:0] load_idx;
	logic            load_class;
	count_t          load_count;
	logic            in_range;
	logic [PW-1:0]   received;
	attr_ctl_t       ctl;
	count_t          rd_neg, rd_pos;
	logic            res_valid;
	result_t         res, out_res;

	// Field unpack
	assign load_idx   = s_axis_tdata[IDX_BITS-1:0];
	assign load_class = s_axis_tdata[IDX_BITS];
	assign load_count = s_axis_tdata[IDX_BITS+COUNT_BITS:IDX_BITS+1];

	// Register writes and reads
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[3:2])
			REG_NUM_ATTR:  prdata = APB_DATA_BITS'(num_attr_q);
			REG_NEG_COUNT: prdata = APB_DATA_BITS'(neg_count_q);
			REG_POS_COUNT: prdata = APB_DATA_BITS'(pos_count_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_attr_q  <= NUM_ATTR_BITS'(1);
			neg_count_q <= '0;
			pos_count_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_NUM_ATTR:  num_attr_q  <= pwdata[NUM_ATTR_BITS-1:0];
				REG_NEG_COUNT: neg_count_q <= pwdata[COUNT_BITS-1:0];
				REG_POS_COUNT: pos_count_q <= pwdata[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Input transfer decode
	assign s_axis_tready = (cred_q < CRED_BITS'(OUT_DEPTH));
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign attr_fire = in_fire && (s_axis_tuser == FUNC_ATTR);
	assign load_fire = in_fire && (s_axis_tuser == FUNC_LOAD);
	assign load_ok   = load_fire && (32'(load_idx) < 32'(MAX_ATTRIBUTES));
	assign res_start = attr_fire && s_axis_tlast;
	assign out_fire  = m_axis_tvalid && m_axis_tready;

	// Attribute position; saturates at MAX_ATTRIBUTES + 1
	always_comb begin
		in_range = (32'(pos_q) < 32'(MAX_ATTRIBUTES));
		received = (32'(pos_q) <= 32'(MAX_ATTRIBUTES)) ? pos_q + 1'b1 : pos_q;
		ctl.attr_bit     = s_axis_tdata[IDX_BITS+COUNT_BITS+1];
		ctl.attr_last    = s_axis_tlast;
		ctl.in_range     = in_range;
		ctl.length_error = (32'(received) != 32'(num_attr_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cred_q <= '0;
		end else begin
			if (attr_fire) begin
				pos_q <= s_axis_tlast ? '0 : received;
			end
			// Reserve queue space per instance, release on output transfer
			cred_q <= cred_q + CRED_BITS'(res_start) - CRED_BITS'(out_fire);
		end
	end

	nbc_count_mem #(
		.DEPTH (MAX_ATTRIBUTES),
		.AW    (AW)
	) u_mem (
		.clk      (clk),
		.wr_en    (load_ok),
		.wr_class (load_class),
		.wr_addr  (AW'(load_idx)),
		.wr_data  (load_count),
		.rd_en    (attr_fire),
		.rd_addr  (AW'(pos_q)),
		.rd_neg   (rd_neg),
		.rd_pos   (rd_pos)
	);

	nbc_score u_score (
		.clk             (clk),
		.arst_n          (arst_n),
		.attr_valid      (attr_fire),
		.attr_ctl        (ctl),
		.rd_neg          (rd_neg),
		.rd_pos          (rd_pos),
		.class_neg_count (neg_count_q),
		.class_pos_count (pos_count_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	nbc_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = M_TDATA_BITS'(out_res);

endmodule

`default_nettype wire

>>> rtl/nbc_count_mem.sv
// Count table: one synchronous memory per class, indexed by attribute,
// one write port for loads and a registered read of both classes.
// Depends on nbc_pkg.
`default_nettype none

module nbc_count_mem import nbc_pkg::*; #(
	parameter int DEPTH = MAX_ATTRIBUTES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic          wr_class,
	input  wire logic [AW-1:0] wr_addr,
	input  wire count_t        wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output count_t             rd_neg,
	output count_t             rd_pos
);

	count_t mem_neg [DEPTH];
	count_t mem_pos [DEPTH];

	// Write one class entry per load transfer
	always_ff @(posedge clk) begin
		if (wr_en && !wr_class) begin
			mem_neg[wr_addr] <= wr_data;
		end
		if (wr_en && wr_class) begin
			mem_pos[wr_addr] <= wr_data;
		end
	end

	// Read both classes of one attribute, data valid next cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_neg <= mem_neg[rd_addr];
			rd_pos <= mem_pos[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/nbc_score.sv
// Score pipeline: log terms from table counts, saturating class accumulators,
// final prior term and class compare. Depends on nbc_pkg.
`default_nettype none

module nbc_score import nbc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      attr_valid,
	input  wire attr_ctl_t attr_ctl,
	input  wire count_t    rd_neg,
	input  wire count_t    rd_pos,
	input  wire count_t    class_neg_count,
	input  wire count_t    class_pos_count,
	output logic           res_valid,
	output result_t        res
);

	// Per-class constants derived from the class totals
	log_t logden_neg_q, logden_pos_q, logtot_neg_q, logtot_pos_q;

	logic      v_s1, v_s2, v_s3, v_s4;
	attr_ctl_t ctl_s1, ctl_s2;
	log_t      logn_neg_s2, logn_pos_s2;
	score_t    acc_neg_q, acc_pos_q;
	logic      lenerr_s3, lenerr_s4;
	score_t    acc_neg_s3, acc_pos_s3;
	score_t    fin_neg_s4, fin_pos_s4;

	count_t n_neg, n_pos;
	term_t  term_neg, term_pos;
	score_t acc_neg_nx, acc_pos_nx;
	score_t fin_neg, fin_pos;
	sign_t  sign_nx;

	// Refresh denominators and prior logs from the totals
	always_ff @(posedge clk) begin
		logden_neg_q <= mitchell_log2(LOG_IN_BITS'({class_neg_count, 1'b0}) + LOG_IN_BITS'(2));
		logden_pos_q <= mitchell_log2(LOG_IN_BITS'({class_pos_count, 1'b0}) + LOG_IN_BITS'(2));
		logtot_neg_q <= mitchell_log2(LOG_IN_BITS'(class_neg_count));
		logtot_pos_q <= mitchell_log2(LOG_IN_BITS'(class_pos_count));
	end

	// Stage 1: counts arrive from memory, take log2(2n+1)
	always_comb begin
		n_neg = pick_count(ctl_s1.attr_bit, rd_neg, class_neg_count);
		n_pos = pick_count(ctl_s1.attr_bit, rd_pos, class_pos_count);
	end

	// Stage 2: term and saturating accumulate
	always_comb begin
		term_neg   = signed'({1'b0, logn_neg_s2}) - signed'({1'b0, logden_neg_q});
		term_pos   = signed'({1'b0, logn_pos_s2}) - signed'({1'b0, logden_pos_q});
		acc_neg_nx = (ctl_s2.in_range && class_neg_count != '0)
		             ? sat_add(acc_neg_q, term_neg) : acc_neg_q;
		acc_pos_nx = (ctl_s2.in_range && class_pos_count != '0)
		             ? sat_add(acc_pos_q, term_pos) : acc_pos_q;
	end

	// Stage 3: add the class prior, empty class scores minimum
	always_comb begin
		fin_neg = (class_neg_count == '0) ? SCORE_MIN
		          : sat_add(acc_neg_s3, signed'({1'b0, logtot_neg_q}));
		fin_pos = (class_pos_count == '0) ? SCORE_MIN
		          : sat_add(acc_pos_s3, signed'({1'b0, logtot_pos_q}));
	end

	// Stage 4: compare the final scores
	always_comb begin
		if (fin_pos_s4 > fin_neg_s4) begin
			sign_nx = SIGN_POS;
		end else if (fin_neg_s4 > fin_pos_s4) begin
			sign_nx = SIGN_NEG;
		end else begin
			sign_nx = SIGN_TIE;
		end
	end

	// Pipeline control and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			res_valid <= 1'b0;
			acc_neg_q <= '0;
			acc_pos_q <= '0;
		end else begin
			v_s1      <= attr_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2 && ctl_s2.attr_last;
			v_s4      <= v_s3;
			res_valid <= v_s4;
			if (v_s2) begin
				// Clear the running scores at the end of an instance
				if (ctl_s2.attr_last) begin
					acc_neg_q <= '0;
					acc_pos_q <= '0;
				end else begin
					acc_neg_q <= acc_neg_nx;
					acc_pos_q <= acc_pos_nx;
				end
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		ctl_s1      <= attr_ctl;
		ctl_s2      <= ctl_s1;
		logn_neg_s2 <= mitchell_log2({1'b0, n_neg, 1'b1});
		logn_pos_s2 <= mitchell_log2({1'b0, n_pos, 1'b1});
		acc_neg_s3  <= acc_neg_nx;
		acc_pos_s3  <= acc_pos_nx;
		lenerr_s3   <= ctl_s2.length_error;
		fin_neg_s4  <= fin_neg;
		fin_pos_s4  <= fin_pos;
		lenerr_s4   <= lenerr_s3;
		res.class_sign   <= sign_nx;
		res.length_error <= lenerr_s4;
		res.neg_score    <= fin_neg_s4;
		res.pos_score    <= fin_pos_s4;
	end

endmodule

`default_nettype wire

>>> rtl/nbc_out_fifo.sv
// Result queue between the score pipeline and the output stream.
// Space is reserved at input acceptance, so a push never finds it full.
// Depends on nbc_pkg.
`default_nettype none

module nbc_out_fifo import nbc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	localparam int PTR_BITS = $clog2(OUT_DEPTH);

	result_t               mem_q [OUT_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PTR_BITS:0]     count_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// Store results
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
		end
	end

endmodule

`default_nettype wire
